>>> rtl/core/mpla_pkg.sv
// ----------------------------------------------------------------------------
// mpla_pkg: shared types and constants for the motor power limit allocator
// Item and result payloads, configuration image, job record, state enums.
// ----------------------------------------------------------------------------
package mpla_pkg;

  localparam int MotorCount = 4;
  localparam int MotorIdxW  = (MotorCount > 1) ? $clog2(MotorCount) : 1;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CurClamp   = 16000;
  localparam int PowerW     = 34;  // saturated Q16.16 motor power, signed
  localparam int TotalW     = 35;  // unsaturated sum of up to four powers
  localparam logic [31:0] PowerSat = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    CfgKCurrentSpeed = 3'd0,
    CfgKSpeedSq      = 3'd1,
    CfgKCurrentSq    = 3'd2,
    CfgStaticPower   = 3'd3,
    CfgPowerLimit    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [31:0] k_current_speed;
    logic signed [31:0] k_speed_sq;
    logic signed [31:0] k_current_sq;
    logic signed [31:0] static_power;
    logic        [30:0] power_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] speed_a;
    logic signed [15:0] speed_b;
    logic signed [15:0] speed_c;
    logic signed [15:0] speed_d;
    logic signed [15:0] drive_a;
    logic signed [15:0] drive_b;
    logic signed [15:0] drive_c;
    logic signed [15:0] drive_d;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] limited_a;
    logic signed [15:0] limited_b;
    logic signed [15:0] limited_c;
    logic signed [15:0] limited_d;
    logic        [31:0] total_power;
    logic               over_limit;
  } out_item_t;

  typedef struct packed {
    logic [MotorCount-1:0][15:0]       speed;
    logic [MotorCount-1:0][15:0]       drive;
    logic [MotorCount-1:0][PowerW-1:0] power;
    logic [TotalW-1:0]                 total;
    logic                              over;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE, F_PROD, F_MAC0, F_MAC1, F_MAC2, F_SUM, F_PUSH
  } front_state_e;

  typedef enum logic [4:0] {
    B_IDLE, B_START, B_PMUL, B_PDIV, B_BMUL, B_CMUL, B_BB0, B_BB1, B_BB2,
    B_AC0, B_AC1, B_DELTA, B_SQRT, B_QMUL, B_QCHK, B_QDIV, B_NEXT, B_EMIT
  } back_state_e;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

>>> rtl/core/mpla_front.sv
// ----------------------------------------------------------------------------
// mpla_front: power estimate per motor
// Takes an item, evaluates the quadratic power model motor by motor with one
// shared multiplier for the coefficient terms, sums the non-negative powers and hands a job to the queue.
// ----------------------------------------------------------------------------
module mpla_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      start_i,
  output logic                                      busy_o,
  input  logic [mpla_pkg::MotorCount-1:0][15:0]     speed_i,
  input  logic [mpla_pkg::MotorCount-1:0][15:0]     drive_i,
  input  mpla_pkg::cfg_t                            cfg_i,
  input  logic                                      full_i,
  output logic                                      push_o,
  output mpla_pkg::job_t                            job_o
);

  localparam int PowerW = mpla_pkg::PowerW;
  localparam int TotalW = mpla_pkg::TotalW;
  localparam int IdxW   = mpla_pkg::MotorIdxW;

  mpla_pkg::front_state_e state_q, state_d;
  mpla_pkg::job_t         job_q, job_d;
  logic [IdxW-1:0]        m_q, m_d;
  logic signed [31:0]     iw_q, iw_d, ww_q, ww_d, ii_q, ii_d;
  logic signed [63:0]     acc_q, acc_d;
  logic signed [15:0]     w, cur;
  logic signed [31:0]     mul_k, mul_x;
  logic signed [63:0]     mul_p;
  logic signed [55:0]     p_raw;
  logic signed [PowerW-1:0] p_sat;
  logic                   last_motor;

  assign w          = $signed(job_q.speed[m_q]);
  assign cur        = $signed(job_q.drive[m_q]);
  assign mul_p      = mul_k * mul_x;
  assign p_raw      = acc_q[63:8];
  assign last_motor = (m_q == IdxW'(mpla_pkg::MotorCount - 1));
  assign busy_o     = (state_q != mpla_pkg::F_IDLE);

  // floor to Q16.16, then saturate
  always_comb begin
    if (p_raw > $signed(56'(mpla_pkg::PowerSat))) begin
      p_sat = PowerW'($signed(56'(mpla_pkg::PowerSat)));
    end else if (p_raw < -$signed(56'(mpla_pkg::PowerSat))) begin
      p_sat = PowerW'(-$signed(56'(mpla_pkg::PowerSat)));
    end else begin
      p_sat = PowerW'(p_raw);
    end
  end

  always_comb begin
    job_o      = job_q;
    job_o.over = (job_q.total > TotalW'(cfg_i.power_limit));
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    m_d     = m_q;
    iw_d    = iw_q;
    ww_d    = ww_q;
    ii_d    = ii_q;
    acc_d   = acc_q;
    mul_k   = '0;
    mul_x   = '0;
    push_o  = 1'b0;
    case (state_q)
      mpla_pkg::F_IDLE: begin
        if (start_i) begin
          job_d.speed = speed_i;
          job_d.drive = drive_i;
          job_d.total = '0;
          job_d.over  = 1'b0;
          m_d         = '0;
          state_d     = mpla_pkg::F_PROD;
        end
      end
      mpla_pkg::F_PROD: begin
        iw_d    = 32'(cur) * 32'(w);
        ww_d    = 32'(w) * 32'(w);
        ii_d    = 32'(cur) * 32'(cur);
        state_d = mpla_pkg::F_MAC0;
      end
      mpla_pkg::F_MAC0: begin
        mul_k   = cfg_i.k_current_speed;
        mul_x   = iw_q;
        acc_d   = mul_p + (64'(cfg_i.static_power) <<< 8);
        state_d = mpla_pkg::F_MAC1;
      end
      mpla_pkg::F_MAC1: begin
        mul_k   = cfg_i.k_speed_sq;
        mul_x   = ww_q;
        acc_d   = acc_q + mul_p;
        state_d = mpla_pkg::F_MAC2;
      end
      mpla_pkg::F_MAC2: begin
        mul_k   = cfg_i.k_current_sq;
        mul_x   = ii_q;
        acc_d   = acc_q + mul_p;
        state_d = mpla_pkg::F_SUM;
      end
      mpla_pkg::F_SUM: begin
        job_d.power[m_q] = p_sat;
        if (!p_sat[PowerW-1]) begin
          job_d.total = job_q.total + TotalW'(p_sat[31:0]);
        end
        if (last_motor) begin
          state_d = mpla_pkg::F_PUSH;
        end else begin
          m_d     = m_q + 1'b1;
          state_d = mpla_pkg::F_PROD;
        end
      end
      mpla_pkg::F_PUSH: begin
        // hold the job until the queue has room
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = mpla_pkg::F_IDLE;
        end
      end
      default: state_d = mpla_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpla_pkg::F_IDLE;
      m_q     <= '0;
    end else begin
      state_q <= state_d;
      m_q     <= m_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    iw_q  <= iw_d;
    ww_q  <= ww_d;
    ii_q  <= ii_d;
    acc_q <= acc_d;
  end

endmodule

>>> rtl/core/mpla_queue.sv
// ----------------------------------------------------------------------------
// mpla_queue: job queue between estimate and allocation
// Short FIFO of job records; lets the front take new items while the back works.
// ----------------------------------------------------------------------------
module mpla_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mpla_pkg::job_t job_i,
  input  logic           pop_i,
  output logic           empty_o,
  output logic           full_o,
  output mpla_pkg::job_t head_o
);

  localparam int Depth = mpla_pkg::QueueDepth;
  localparam int PtrW  = mpla_pkg::QueuePtrW;
  localparam int CntW  = $clog2(Depth + 1);

  mpla_pkg::job_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

>>> rtl/core/mpla_back.sv
// ----------------------------------------------------------------------------
// mpla_back: current allocation
// Over the limit, splits the limit over the motors and solves the power model for
// each new current with a shared 32x32 multiplier, a radix-2 divider and a bit-pair
// square root unit; within the limit, passes the currents through. Then issues
// the result.
module mpla_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  mpla_pkg::cfg_t                        cfg_i,
  input  logic                                  empty_i,
  input  mpla_pkg::job_t                        head_i,
  output logic                                  pop_o,
  output logic                                  strobe_o,
  output logic [mpla_pkg::MotorCount-1:0][15:0] limited_o,
  output logic [31:0]                           total_o,
  output logic                                  over_o
);

  localparam int IdxW      = mpla_pkg::MotorIdxW;
  localparam int PowerW    = mpla_pkg::PowerW;
  localparam int PcmdSteps = 32;
  localparam int SqrtSteps = 48;
  localparam int QuoSteps  = 14;
  localparam logic [31:0] ClampNext = 32'(mpla_pkg::CurClamp + 1);
  localparam logic [15:0] ClampPos  = 16'(mpla_pkg::CurClamp);

  mpla_pkg::back_state_e state_q, state_d;
  mpla_pkg::job_t        job_q, job_d;
  logic [IdxW-1:0]       m_q, m_d;
  logic [5:0]            cnt_q, cnt_d;
  logic [mpla_pkg::MotorCount-1:0][15:0] lim_q, lim_d;
  logic [35:0]           rem_q, rem_d;
  logic [31:0]           dvd_q, dvd_d, quo_q, quo_d;
  logic                  pneg_q, pneg_d;
  logic [31:0]           ww_q, ww_d;
  logic [47:0]           bmag_q, bmag_d;
  logic                  bneg_q, bneg_d;
  logic signed [33:0]    t_q, t_d;
  logic signed [63:0]    c_q, c_d;
  logic [95:0]           bb_q, bb_d, ac_q, ac_d, rad_q, rad_d;
  logic [49:0]           srem_q, srem_d;
  logic [47:0]           root_q, root_d;
  logic [49:0]           nmag_q, nmag_d;
  logic                  nneg_q, nneg_d;
  logic [45:0]           thr_q, thr_d;

  logic [31:0]           mul_a, mul_b;
  logic [63:0]           mul_p;
  logic signed [15:0]    w, cur;
  logic [15:0]           wmag;
  logic signed [PowerW-1:0] p;
  logic [31:0]           pmag, k0mag, k1mag, k2mag;
  logic                  k0neg, k1neg, k2neg;
  logic [63:0]           cmag;
  logic signed [63:0]    k1term;
  logic signed [33:0]    pcmd;
  logic [35:0]           divisor, div_trial;
  logic                  div_ge;
  logic [51:0]           sq_rem2, sq_trial;
  logic [95:0]           ac4;
  logic signed [49:0]    bsig, sroot, num;
  logic                  c_opp, qneg, last_motor;
  logic [13:0]           qm;

  assign w     = $signed(job_q.speed[m_q]);
  assign cur   = $signed(job_q.drive[m_q]);
  assign wmag  = w[15] ? 16'(-w) : 16'(w);
  assign p     = $signed(job_q.power[m_q]);
  assign pmag  = p[PowerW-1] ? 32'(-p) : p[31:0];
  assign k0mag = mpla_pkg::mag32(cfg_i.k_current_speed);
  assign k1mag = mpla_pkg::mag32(cfg_i.k_speed_sq);
  assign k2mag = mpla_pkg::mag32(cfg_i.k_current_sq);
  assign k0neg = cfg_i.k_current_speed[31];
  assign k1neg = cfg_i.k_speed_sq[31];
  assign k2neg = cfg_i.k_current_sq[31];
  assign mul_p = 64'(mul_a) * 64'(mul_b);
  assign cmag  = c_q[63] ? 64'(-c_q) : 64'(c_q);
  assign k1term = k1neg ? -$signed({1'b0, mul_p[62:0]}) : $signed({1'b0, mul_p[62:0]});
  assign pcmd  = pneg_q ? -$signed({2'b0, quo_q}) : $signed({2'b0, quo_q});

  // one divider, two divisors: the power total, then twice |k_current_sq|
  assign divisor   = (state_q == mpla_pkg::B_QDIV) ? 36'({k2mag, 1'b0}) : 36'(job_q.total);
  assign div_trial = {rem_q[34:0], dvd_q[31]};
  assign div_ge    = (div_trial >= divisor);

  assign sq_rem2  = {srem_q, rad_q[95:94]};
  assign sq_trial = 52'({root_q, 2'b01});
  assign ac4      = {ac_q[93:0], 2'b00};
  assign c_opp    = (k2neg != c_q[63]) || (c_q == '0);

  assign bsig  = bneg_q ? -$signed({2'b0, bmag_q}) : $signed({2'b0, bmag_q});
  assign sroot = $signed({2'b0, root_q});
  assign num   = (cur > 16'sd0) ? (sroot - bsig) : (-bsig - sroot);
  assign qneg  = nneg_q ^ k2neg;
  assign qm    = quo_d[13:0];
  assign last_motor = (m_q == IdxW'(mpla_pkg::MotorCount - 1));

  assign strobe_o  = (state_q == mpla_pkg::B_EMIT);
  assign limited_o = lim_q;
  assign total_o   = (job_q.total > 35'(mpla_pkg::PowerSat)) ? mpla_pkg::PowerSat
                                                              : job_q.total[31:0];
  assign over_o    = job_q.over;

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    m_d     = m_q;
    cnt_d   = cnt_q;
    lim_d   = lim_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    pneg_d  = pneg_q;
    ww_d    = ww_q;
    bmag_d  = bmag_q;
    bneg_d  = bneg_q;
    t_d     = t_q;
    c_d     = c_q;
    bb_d    = bb_q;
    ac_d    = ac_q;
    rad_d   = rad_q;
    srem_d  = srem_q;
    root_d  = root_q;
    nmag_d  = nmag_q;
    nneg_d  = nneg_q;
    thr_d   = thr_q;
    mul_a   = '0;
    mul_b   = '0;
    pop_o   = 1'b0;
    if (state_q == mpla_pkg::B_PDIV || state_q == mpla_pkg::B_QDIV) begin
      rem_d = div_ge ? (div_trial - divisor) : div_trial;
      quo_d = {quo_q[30:0], div_ge};
      dvd_d = {dvd_q[30:0], 1'b0};
    end
    case (state_q)
      mpla_pkg::B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          job_d = head_i;
          m_d   = '0;
          if (head_i.over) begin
            state_d = mpla_pkg::B_START;
          end else begin
            lim_d   = head_i.drive;
            state_d = mpla_pkg::B_EMIT;
          end
        end
      end
      mpla_pkg::B_START: begin
        if (cfg_i.k_current_sq == '0) begin
          lim_d[m_q] = cur;
          state_d    = mpla_pkg::B_NEXT;
        end else begin
          state_d = mpla_pkg::B_PMUL;
        end
      end
      mpla_pkg::B_PMUL: begin
        mul_a   = {1'b0, cfg_i.power_limit};
        mul_b   = pmag;
        rem_d   = 36'(mul_p[62:32]);
        dvd_d   = mul_p[31:0];
        quo_d   = '0;
        pneg_d  = p[PowerW-1];
        ww_d    = 32'(wmag) * 32'(wmag);
        cnt_d   = '0;
        state_d = mpla_pkg::B_PDIV;
      end
      mpla_pkg::B_PDIV: begin
        if (cnt_q == 6'(PcmdSteps - 1)) begin
          state_d = mpla_pkg::B_BMUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      mpla_pkg::B_BMUL: begin
        mul_a   = k0mag;
        mul_b   = 32'(wmag);
        bmag_d  = mul_p[47:0];
        bneg_d  = k0neg ^ w[15];
        t_d     = 34'(cfg_i.static_power) - pcmd;
        state_d = mpla_pkg::B_CMUL;
      end
      mpla_pkg::B_CMUL: begin
        mul_a   = k1mag;
        mul_b   = ww_q;
        c_d     = k1term + (64'(t_q) <<< 8);
        state_d = mpla_pkg::B_BB0;
      end
      mpla_pkg::B_BB0: begin
        mul_a   = {8'b0, bmag_q[23:0]};
        mul_b   = {8'b0, bmag_q[23:0]};
        bb_d    = 96'(mul_p);
        state_d = mpla_pkg::B_BB1;
      end
      mpla_pkg::B_BB1: begin
        mul_a   = {8'b0, bmag_q[47:24]};
        mul_b   = {8'b0, bmag_q[23:0]};
        bb_d    = bb_q + (96'(mul_p) << 25);
        state_d = mpla_pkg::B_BB2;
      end
      mpla_pkg::B_BB2: begin
        mul_a   = {8'b0, bmag_q[47:24]};
        mul_b   = {8'b0, bmag_q[47:24]};
        bb_d    = bb_q + (96'(mul_p) << 48);
        state_d = mpla_pkg::B_AC0;
      end
      mpla_pkg::B_AC0: begin
        mul_a   = k2mag;
        mul_b   = cmag[31:0];
        ac_d    = 96'(mul_p);
        state_d = mpla_pkg::B_AC1;
      end
      mpla_pkg::B_AC1: begin
        mul_a   = k2mag;
        mul_b   = cmag[63:32];
        ac_d    = ac_q + (96'(mul_p) << 32);
        state_d = mpla_pkg::B_DELTA;
      end
      mpla_pkg::B_DELTA: begin
        srem_d = '0;
        root_d = '0;
        cnt_d  = '0;
        if (c_opp) begin
          rad_d   = bb_q + ac4;
          state_d = mpla_pkg::B_SQRT;
        end else if (ac4 > bb_q) begin
          // no real root: keep the commanded current
          lim_d[m_q] = cur;
          state_d    = mpla_pkg::B_NEXT;
        end else begin
          rad_d   = bb_q - ac4;
          state_d = mpla_pkg::B_SQRT;
        end
      end
      mpla_pkg::B_SQRT: begin
        if (sq_rem2 >= sq_trial) begin
          srem_d = 50'(sq_rem2 - sq_trial);
          root_d = {root_q[46:0], 1'b1};
        end else begin
          srem_d = 50'(sq_rem2);
          root_d = {root_q[46:0], 1'b0};
        end
        rad_d = {rad_q[93:0], 2'b00};
        if (cnt_q == 6'(SqrtSteps - 1)) begin
          state_d = mpla_pkg::B_QMUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      mpla_pkg::B_QMUL: begin
        mul_a   = k2mag;
        mul_b   = ClampNext;
        thr_d   = mul_p[45:0];
        nneg_d  = num[49];
        nmag_d  = num[49] ? 50'(-num) : 50'(num);
        state_d = mpla_pkg::B_QCHK;
      end
      mpla_pkg::B_QCHK: begin
        // |num| / 2|a| past the clamp: skip the division
        if (nmag_q[49:1] >= 49'(thr_q)) begin
          lim_d[m_q] = qneg ? 16'(-ClampPos) : ClampPos;
          state_d    = mpla_pkg::B_NEXT;
        end else begin
          rem_d   = 36'(nmag_q[49:14]);
          dvd_d   = {nmag_q[13:0], 18'b0};
          quo_d   = '0;
          cnt_d   = '0;
          state_d = mpla_pkg::B_QDIV;
        end
      end
      mpla_pkg::B_QDIV: begin
        if (cnt_q == 6'(QuoSteps - 1)) begin
          lim_d[m_q] = qneg ? 16'(-{2'b0, qm}) : {2'b0, qm};
          state_d    = mpla_pkg::B_NEXT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      mpla_pkg::B_NEXT: begin
        if (last_motor) begin
          state_d = mpla_pkg::B_EMIT;
        end else begin
          m_d     = m_q + 1'b1;
          state_d = mpla_pkg::B_START;
        end
      end
      mpla_pkg::B_EMIT: state_d = mpla_pkg::B_IDLE;
      default:          state_d = mpla_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpla_pkg::B_IDLE;
      m_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      m_q     <= m_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    lim_q  <= lim_d;
    rem_q  <= rem_d;
    dvd_q  <= dvd_d;
    quo_q  <= quo_d;
    pneg_q <= pneg_d;
    ww_q   <= ww_d;
    bmag_q <= bmag_d;
    bneg_q <= bneg_d;
    t_q    <= t_d;
    c_q    <= c_d;
    bb_q   <= bb_d;
    ac_q   <= ac_d;
    rad_q  <= rad_d;
    srem_q <= srem_d;
    root_q <= root_d;
    nmag_q <= nmag_d;
    nneg_q <= nneg_d;
    thr_q  <= thr_d;
  end

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("result strobe held longer than one cycle");

  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !over_o) |-> (limited_o == job_q.drive))
    else $error("currents changed although total within limit");

  a_over_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (over_o == (job_q.total > 35'(cfg_i.power_limit))))
    else $error("over flag disagrees with total and limit");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("job taken from an empty queue");

endmodule

>>> rtl/core/motor_power_limit_allocator.sv
// ----------------------------------------------------------------------------
// motor_power_limit_allocator: chassis power limiter, quadratic motor model
// Flow: the front takes a new item only once its last job is in the queue; over
//   the limit, the back runs a serial divider (32 + 14 steps) and a 48-step
//   square root per motor. Two jobs can wait for the allocator, and results
//   never stall since the receiver cannot.
// Reset: control and configuration clear asynchronously; datapath registers have no reset.
// ----------------------------------------------------------------------------
module motor_power_limit_allocator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i,
  input  logic                 start,
  output logic                 busy,
  input  mpla_pkg::in_item_t   item_i,
  output logic                 result_strobe_o,
  output mpla_pkg::out_item_t  result_o
);

  mpla_pkg::cfg_t cfg_q;
  logic [mpla_pkg::MotorCount-1:0][15:0] speed, drive, limited;
  mpla_pkg::job_t push_job, head_job;
  logic push, pop, q_full, q_empty, over;
  logic [31:0] total;

  // Configuration image: the user must write it only while the block is idle; the block itself does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.k_current_speed <= '0;
      cfg_q.k_speed_sq      <= '0;
      cfg_q.k_current_sq    <= '0;
      cfg_q.static_power    <= '0;
      cfg_q.power_limit     <= 31'd6553600;  // 100 W in Q16.16
    end else if (cfg_we_i) begin
      case (mpla_pkg::cfg_idx_e'(cfg_idx_i))
        mpla_pkg::CfgKCurrentSpeed: cfg_q.k_current_speed <= cfg_wdata_i;
        mpla_pkg::CfgKSpeedSq:      cfg_q.k_speed_sq      <= cfg_wdata_i;
        mpla_pkg::CfgKCurrentSq:    cfg_q.k_current_sq    <= cfg_wdata_i;
        mpla_pkg::CfgStaticPower:   cfg_q.static_power    <= cfg_wdata_i;
        mpla_pkg::CfgPowerLimit:    cfg_q.power_limit     <= cfg_wdata_i[30:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Unpack the item into per-motor lanes.
  assign speed[0] = item_i.speed_a;
  assign speed[1] = item_i.speed_b;
  assign speed[2] = item_i.speed_c;
  assign speed[3] = item_i.speed_d;
  assign drive[0] = item_i.drive_a;
  assign drive[1] = item_i.drive_b;
  assign drive[2] = item_i.drive_c;
  assign drive[3] = item_i.drive_d;

  // Front: power estimate and total, one motor at a time.
  mpla_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .speed_i (speed),
    .drive_i (drive),
    .cfg_i   (cfg_q),
    .full_i  (q_full),
    .push_o  (push),
    .job_o   (push_job)
  );

  // Queue: decouple estimate from allocation.
  mpla_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .empty_o (q_empty),
    .full_o  (q_full),
    .head_o  (head_job)
  );

  // Back: split the limit and solve for new currents when over it; one transfer per job.
  mpla_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .empty_i   (q_empty),
    .head_i    (head_job),
    .pop_o     (pop),
    .strobe_o  (result_strobe_o),
    .limited_o (limited),
    .total_o   (total),
    .over_o    (over)
  );

  assign result_o.limited_a   = limited[0];
  assign result_o.limited_b   = limited[1];
  assign result_o.limited_c   = limited[2];
  assign result_o.limited_d   = limited[3];
  assign result_o.total_power = total;
  assign result_o.over_limit  = over;

endmodule

>>> tb/mpla_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpla_checker: predicts and checks the power limit allocator's results
// Snoops configuration writes and accepted items, computes the expected
// limited currents, total and over-limit flag, and compares each result.
// ----------------------------------------------------------------------------
module mpla_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                start_i,
  input  logic                busy_i,
  input  mpla_pkg::in_item_t  item_i,
  input  logic                result_strobe_i,
  input  mpla_pkg::out_item_t result_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  localparam longint PwrSat = 64'sd4294967295;

  longint k_cur_speed, k_spd_sq, k_cur_sq, static_pwr, pwr_limit;
  mpla_pkg::out_item_t expected_q[$];

  assign pending_o = expected_q.size();

  function automatic longint sat_power(longint x);
    if (x > PwrSat) return PwrSat;
    if (x < -PwrSat) return -PwrSat;
    return x;
  endfunction

  // Solve the motor model for a current; return 0 when there is no root or k_cur_sq is zero.
  function automatic bit solve_current(longint w, longint cur, longint pcmd,
                                       output longint res);
    longint b, c, num, den, q;
    logic signed [127:0] b_w, a_w, c_w, disc;
    logic [127:0] t_w;
    longint unsigned root, t;
    res = cur;
    if (k_cur_sq == 0) return 0;
    b = k_cur_speed * w;
    c = k_spd_sq * (w * w) + (static_pwr - pcmd) * 256;
    b_w = b;
    a_w = k_cur_sq;
    c_w = c;
    disc = b_w * b_w - 4 * a_w * c_w;
    if (disc < 0) return 0;
    root = 0;
    for (int k = 50; k >= 0; k--) begin
      t = root | (64'd1 << k);
      t_w = t;
      if (t_w * t_w <= disc) root = t;
    end
    num = (cur > 0) ? (-b + longint'(root)) : (-b - longint'(root));
    den = 2 * k_cur_sq;
    q = num / den;
    if (q > mpla_pkg::CurClamp) q = mpla_pkg::CurClamp;
    if (q < -mpla_pkg::CurClamp) q = -mpla_pkg::CurClamp;
    res = q;
    return 1;
  endfunction

  function automatic mpla_pkg::out_item_t predict_limits(mpla_pkg::in_item_t it);
    mpla_pkg::out_item_t o;
    longint w[4], cur[4], pwr[4], lim[4];
    longint acc, total, pcmd, q;
    bit over;
    w = '{longint'(it.speed_a), longint'(it.speed_b),
          longint'(it.speed_c), longint'(it.speed_d)};
    cur = '{longint'(it.drive_a), longint'(it.drive_b),
            longint'(it.drive_c), longint'(it.drive_d)};
    total = 0;
    for (int i = 0; i < 4; i++) begin
      acc = k_cur_speed * (cur[i] * w[i]) + k_spd_sq * (w[i] * w[i])
          + k_cur_sq * (cur[i] * cur[i]) + static_pwr * 256;
      pwr[i] = sat_power(acc >>> 8);  // arithmetic shift floors
      if (pwr[i] >= 0) total += pwr[i];
    end
    over = total > pwr_limit;
    for (int i = 0; i < 4; i++) begin
      lim[i] = cur[i];
      if (over) begin
        pcmd = sat_power((pwr_limit * pwr[i]) / total);
        if (solve_current(w[i], cur[i], pcmd, q)) lim[i] = q;
      end
    end
    o.limited_a   = 16'(lim[0]);
    o.limited_b   = 16'(lim[1]);
    o.limited_c   = 16'(lim[2]);
    o.limited_d   = 16'(lim[3]);
    o.total_power = (total > PwrSat) ? 32'hFFFF_FFFF : 32'(total);
    o.over_limit  = over;
    return o;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_cur_speed <= 0;
      k_spd_sq    <= 0;
      k_cur_sq    <= 0;
      static_pwr  <= 0;
      pwr_limit   <= 6553600;
    end else if (cfg_we_i) begin
      case (mpla_pkg::cfg_idx_e'(cfg_idx_i))
        mpla_pkg::CfgKCurrentSpeed: k_cur_speed <= longint'($signed(cfg_wdata_i));
        mpla_pkg::CfgKSpeedSq:      k_spd_sq    <= longint'($signed(cfg_wdata_i));
        mpla_pkg::CfgKCurrentSq:    k_cur_sq    <= longint'($signed(cfg_wdata_i));
        mpla_pkg::CfgStaticPower:   static_pwr  <= longint'($signed(cfg_wdata_i));
        mpla_pkg::CfgPowerLimit:    pwr_limit   <= longint'(cfg_wdata_i[30:0]);
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    mpla_pkg::out_item_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) expected_q.push_back(predict_limits(item_i));
      if (result_strobe_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("results outstanding", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (result_i.limited_a != want.limited_a)
            report_mismatch("limited_a", result_i.limited_a, want.limited_a);
          if (result_i.limited_b != want.limited_b)
            report_mismatch("limited_b", result_i.limited_b, want.limited_b);
          if (result_i.limited_c != want.limited_c)
            report_mismatch("limited_c", result_i.limited_c, want.limited_c);
          if (result_i.limited_d != want.limited_d)
            report_mismatch("limited_d", result_i.limited_d, want.limited_d);
          if (result_i.total_power != want.total_power)
            report_mismatch("total_power", result_i.total_power, want.total_power);
          if (result_i.over_limit != want.over_limit)
            report_mismatch("over_limit", result_i.over_limit, want.over_limit);
        end
      end
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the motor power limit allocator
// Runs phases of coefficient settings with random motor items, directed ones first in
// phase 0, and random start gaps outside phase 2; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;

  localparam int StallLimit  = 30000;  // a few over-limit jobs queued, with margin
  localparam int DrainCycles = 600;    // longest allocator run plus margin
  localparam int PhaseCount  = 8;
  localparam int PhaseItems  = 205;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [2:0]          cfg_idx_i = '0;
  logic [31:0]         cfg_wdata_i = '0;
  logic                start = 1'b0;
  logic                busy;
  mpla_pkg::in_item_t  item_i = '0;
  logic                result_strobe_o;
  mpla_pkg::out_item_t result_o;
  int                  fail_count, pending;
  int                  idle_cycles;
  bit                  allow_idle = 1'b1;

  motor_power_limit_allocator u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .start, .busy, .item_i, .result_strobe_o, .result_o
  );

  mpla_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .start_i(start), .busy_i(busy), .item_i,
    .result_strobe_i(result_strobe_o), .result_i(result_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Load all five registers in back-to-back cycles; hold the enable high.
  task automatic load_coeffs(logic [31:0] kcs, logic [31:0] kss, logic [31:0] kcq,
                             logic [31:0] sp, logic [31:0] lim);
    logic [31:0] vals[5];
    vals = '{kcs, kss, kcq, sp, lim};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= 3'(mpla_pkg::cfg_idx_e'(i));
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  // Present one item and hold it until the block takes the transfer.
  task automatic send_motors(mpla_pkg::in_item_t it);
    if (allow_idle && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  // Drain outstanding results, then let the back end settle.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_speed();
    case ($urandom_range(0, 9))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'(16'($urandom_range(0, 400)) - 16'd200);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_drive();
    case ($urandom_range(0, 9))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return '0;
      default: return 16'($urandom_range(0, 32768)) - 16'd16384;
    endcase
  endfunction

  function automatic mpla_pkg::in_item_t rand_motors();
    mpla_pkg::in_item_t it;
    it.speed_a = rand_speed();
    it.speed_b = rand_speed();
    it.speed_c = rand_speed();
    it.speed_d = rand_speed();
    it.drive_a = rand_drive();
    it.drive_b = rand_drive();
    it.drive_c = rand_drive();
    it.drive_d = rand_drive();
    return it;
  endfunction

  // Pick a coefficient set per phase: realistic, pass-through and extremes.
  task automatic apply_phase(int ph);
    case (ph)
      0: load_coeffs(32'd40, 32'd10, 32'd60, 32'd65536, 32'd6553600);
      1: load_coeffs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF);
      2: load_coeffs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h0000_0000);
      3: load_coeffs($urandom_range(0, 200), $urandom_range(0, 100), 32'd0,
                     $urandom_range(0, 200000), $urandom_range(0, 1 << 24));
      4: load_coeffs(-$urandom_range(0, 200), $urandom_range(0, 100),
                     -$urandom_range(1, 200), -$urandom_range(0, 200000),
                     $urandom_range(0, 1 << 22));
      5: load_coeffs($urandom, $urandom, $urandom, $urandom, $urandom);
      default: load_coeffs($urandom_range(0, 200), $urandom_range(0, 100),
                           $urandom_range(1, 200), $urandom_range(0, 200000),
                           $urandom_range(0, 1 << 24));
    endcase
  endtask

  initial begin
    mpla_pkg::in_item_t it;
    idle_cycles = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int ph = 0; ph < PhaseCount; ph++) begin
      apply_phase(ph);
      allow_idle = (ph != 2);  // one phase runs with no start gaps
      if (ph == 0) begin
        // Directed corners: extreme speeds and currents, zero current, then random items.
        for (int d = 0; d < 12; d++) begin
          it = '0;
          case (d)
            0: it = '0;
            1: it = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                      16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384};
            2: it = '{16'h8000, 16'h8000, 16'h8000, 16'h8000,
                      -16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384};
            3: it = '{16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                      16'sd16384, -16'sd16384, 16'sd0, 16'sd1};
            4: it = '{16'd100, 16'd100, 16'd100, 16'd100, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
            5: it = '{16'd3000, -16'sd3000, 16'd0, 16'd1,
                      16'sd8000, -16'sd8000, 16'sd100, -16'sd1};
            default: it = rand_motors();
          endcase
          send_motors(it);
        end
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if (ph == 3 && n == 100) wait_drained();  // sender holds off until all arrive
        send_motors(rand_motors());
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
